>>> src/mtt_pkg.sv
// Package for the masked-tag translation buffer: sizes, request kinds and
// the match result passed between the compare unit and the core.
// No dependencies.
package mtt_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int DATA_W  = 32;
    localparam int SLOT_W  = 4;

    typedef enum logic [1:0] {
        KIND_LOOKUP  = 2'd0,
        KIND_INSERT  = 2'd1,
        KIND_INV_ALL = 2'd2,
        KIND_INV_ONE = 2'd3
    } kind_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } match_t;

endpackage

>>> src/mtt_req_if.sv
// Request and response channels of the masked-tag translation buffer.
// Depends on mtt_pkg.
interface mtt_req_if;
    logic                       valid;
    logic                       ready;
    mtt_pkg::kind_t             kind;
    logic [mtt_pkg::DATA_W-1:0] vaddr;
    logic [mtt_pkg::DATA_W-1:0] entry_mask;
    logic [mtt_pkg::DATA_W-1:0] entry_payload;

    modport source (output valid, kind, vaddr, entry_mask, entry_payload, input ready);
    modport sink   (input valid, kind, vaddr, entry_mask, entry_payload, output ready);
    modport monitor (input valid, ready, kind, vaddr, entry_mask, entry_payload);
endinterface

interface mtt_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic [mtt_pkg::SLOT_W-1:0] slot;
    logic [mtt_pkg::DATA_W-1:0] hit_payload;
    logic [mtt_pkg::DATA_W-1:0] hit_mask;

    modport source (output valid, hit, slot, hit_payload, hit_mask, input ready);
    modport sink   (input valid, hit, slot, hit_payload, hit_mask, output ready);
    modport monitor (input valid, ready, hit, slot, hit_payload, hit_mask);
endinterface

>>> src/masked_tag_tlb_core.sv
// Top level of the masked-tag translation buffer: input register, table,
// round-robin fill pointer and result register. Depends on mtt_pkg,
// mtt_req_if, mtt_rsp_if and mtt_match.
//
// Usage:
//   req carries one beat per operation: kind (lookup, insert, invalidate
//   all, invalidate single), vaddr, entry_mask and entry_payload. rsp
//   returns exactly one beat per request: hit, slot, hit_payload, hit_mask.
//   lock_we/lock_wdata write the lock register; while it is set, inserts
//   leave the table untouched and report a miss. Write it only while idle.
//
//   A request beat is captured in the input register, processed from there
//   into the result register, and its response is valid from the result
//   register; a stall on rsp can hold the beat in the input register.
//   Throughput: one beat per cycle while rsp does not stall, set by the
//   combinational parallel compare of all 16 entries followed by the
//   table update.
//
//   Reset clears the valid bits, the fill pointer, the lock register and
//   the valid flags of both pipeline registers; tag, mask and payload
//   storage is not cleared.
//   When rsp stalls, the result register holds its beat, one more request
//   waits in the input register, and req.ready drops until rsp drains.
module masked_tag_tlb_core
(
    input  logic          clk,
    input  logic          rst_n,
    mtt_req_if.sink       req,
    mtt_rsp_if.source     rsp,
    input  logic          lock_we,
    input  logic          lock_wdata
);

    localparam int ENTRIES = mtt_pkg::ENTRIES;
    localparam int IDX_W   = mtt_pkg::IDX_W;
    localparam int DATA_W  = mtt_pkg::DATA_W;
    localparam int SLOT_W  = mtt_pkg::SLOT_W;

    // Configuration
    logic lock_reg;

    // Input register
    logic               in_valid_reg;
    mtt_pkg::kind_t     in_kind_reg;
    logic [DATA_W-1:0]  in_vaddr_reg;
    logic [DATA_W-1:0]  in_mask_reg;
    logic [DATA_W-1:0]  in_payload_reg;

    // Table
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [DATA_W-1:0]  tag_reg     [ENTRIES];
    logic [DATA_W-1:0]  mask_reg    [ENTRIES];
    logic [DATA_W-1:0]  payload_reg [ENTRIES];
    logic [IDX_W-1:0]   ptr_reg;
    logic [IDX_W-1:0]   ptr_next;

    // Result register
    logic               out_valid_reg;
    logic               out_hit_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [DATA_W-1:0]  out_payload_reg;
    logic [DATA_W-1:0]  out_mask_reg;

    logic               out_hit_next;
    logic [SLOT_W-1:0]  out_slot_next;
    logic [DATA_W-1:0]  out_payload_next;
    logic [DATA_W-1:0]  out_mask_next;

    logic               advance;
    logic               fire;
    logic               wr_en;
    logic [IDX_W-1:0]   ins_idx;
    mtt_pkg::match_t    match;

    // Result register can take a beat when empty or being drained.
    assign advance   = !out_valid_reg || rsp.ready;
    assign fire      = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.slot        = out_slot_reg;
    assign rsp.hit_payload = out_payload_reg;
    assign rsp.hit_mask    = out_mask_reg;

    mtt_match u_match
    (
        .vaddr  (in_vaddr_reg),
        .valid  (valid_reg),
        .tags   (tag_reg),
        .masks  (mask_reg),
        .result (match)
    );

    // Next insert slot: pointer plus one, wrapping at the last entry.
    assign ins_idx = (ptr_reg == IDX_W'(ENTRIES - 1)) ? '0 : ptr_reg + IDX_W'(1);

    always_comb
    begin
        valid_next       = valid_reg;
        ptr_next         = ptr_reg;
        wr_en            = 1'b0;
        out_hit_next     = 1'b0;
        out_slot_next    = '0;
        out_payload_next = '0;
        out_mask_next    = '0;

        case (in_kind_reg)
            mtt_pkg::KIND_LOOKUP, mtt_pkg::KIND_INV_ONE:
            begin
                if (match.found)
                begin
                    out_hit_next     = 1'b1;
                    out_slot_next    = SLOT_W'(match.idx);
                    out_payload_next = payload_reg[match.idx];
                    out_mask_next    = mask_reg[match.idx];
                    if (in_kind_reg == mtt_pkg::KIND_INV_ONE)
                    begin
                        valid_next[match.idx] = 1'b0;
                    end
                end
            end
            mtt_pkg::KIND_INSERT:
            begin
                if (!lock_reg)
                begin
                    valid_next[ins_idx] = 1'b1;
                    ptr_next            = ins_idx;
                    wr_en               = 1'b1;
                    out_hit_next        = 1'b1;
                    out_slot_next       = SLOT_W'(ins_idx);
                end
            end
            mtt_pkg::KIND_INV_ALL:
            begin
                valid_next = '0;
                ptr_next   = '0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_reg      <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            ptr_reg       <= '0;
        end
        else
        begin
            if (lock_we)
            begin
                lock_reg <= lock_wdata;
            end
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                valid_reg <= valid_next;
                ptr_reg   <= ptr_next;
            end
        end
    end

    // Payload registers: load on beat, no reset.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_kind_reg    <= req.kind;
            in_vaddr_reg   <= req.vaddr;
            in_mask_reg    <= req.entry_mask;
            in_payload_reg <= req.entry_payload;
        end
        if (fire)
        begin
            out_hit_reg     <= out_hit_next;
            out_slot_reg    <= out_slot_next;
            out_payload_reg <= out_payload_next;
            out_mask_reg    <= out_mask_next;
        end
        if (fire && wr_en)
        begin
            tag_reg[ins_idx]     <= in_vaddr_reg;
            mask_reg[ins_idx]    <= in_mask_reg;
            payload_reg[ins_idx] <= in_payload_reg;
        end
    end

endmodule

>>> src/mtt_match.sv
// Parallel masked tag compare with lowest-slot priority select.
// Depends on mtt_pkg.
module mtt_match
(
    input  logic [mtt_pkg::DATA_W-1:0]  vaddr,
    input  logic [mtt_pkg::ENTRIES-1:0] valid,
    input  logic [mtt_pkg::DATA_W-1:0]  tags  [mtt_pkg::ENTRIES],
    input  logic [mtt_pkg::DATA_W-1:0]  masks [mtt_pkg::ENTRIES],
    output mtt_pkg::match_t             result
);

    logic [mtt_pkg::ENTRIES-1:0] hit_vec;

    always_comb
    begin
        for (int i = 0; i < mtt_pkg::ENTRIES; i++)
        begin
            hit_vec[i] = valid[i] && ((vaddr & ~masks[i]) == tags[i]);
        end
    end

    // Scan downward so the lowest matching slot wins.
    always_comb
    begin
        result.found = 1'b0;
        result.idx   = '0;
        for (int i = mtt_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                result.found = 1'b1;
                result.idx   = mtt_pkg::IDX_W'(i);
            end
        end
    end

endmodule

>>> src/mtt_checker.sv
// Port-level checks for masked_tag_tlb_core, attached with a bind.
// Depends on mtt_pkg and masked_tag_tlb_core.
module mtt_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic                       rsp_hit,
    input logic [mtt_pkg::SLOT_W-1:0] rsp_slot,
    input logic [mtt_pkg::DATA_W-1:0] rsp_hit_payload,
    input logic [mtt_pkg::DATA_W-1:0] rsp_hit_mask
);

    // Hold a stalled response beat.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_hit))
        else $error("response beat dropped or changed while stalled");

    // Misses report zero slot, payload and mask.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit |-> rsp_slot == '0 && rsp_hit_payload == '0
                                  && rsp_hit_mask == '0)
        else $error("miss beat carries nonzero fields");

    // Back-pressure on req only while a response is stalled.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("request side stalled without a stalled response");

    // A fresh response comes from a request accepted through the input register.
    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("response appeared without a matching request");

endmodule

bind masked_tag_tlb_core mtt_checker u_mtt_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_hit         (rsp.hit),
    .rsp_slot        (rsp.slot),
    .rsp_hit_payload (rsp.hit_payload),
    .rsp_hit_mask    (rsp.hit_mask)
);
